### rtl/ehs_pkg.sv
// package for the extendible hash set: sizes, codes and sequencer states
`timescale 1ns / 1ps
package ehs_pkg;
  localparam int MaxGlobalDepth = 10;
  localparam int BucketSlots    = 8;
  localparam int DirSize        = 1 << MaxGlobalDepth;
  localparam int DirW           = MaxGlobalDepth;
  localparam int SlotW          = $clog2(BucketSlots);
  localparam int FillW          = $clog2(BucketSlots + 1);
  localparam int GdW            = 4;
  localparam int KeyAddrW       = DirW + SlotW;

  localparam logic [1:0] FuncContains = 2'd0;
  localparam logic [1:0] FuncInsert   = 2'd1;
  localparam logic [1:0] FuncRemove   = 2'd2;

  localparam logic [1:0] ResOk     = 2'd0;
  localparam logic [1:0] ResMiss   = 2'd1;
  localparam logic [1:0] ResFull   = 2'd2;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_DIR_RD, ST_BKT_RD, ST_SCAN_RD, ST_SCAN_CHK, ST_DECIDE,
    ST_RM_RD, ST_RM_WR, ST_INS, ST_DBL_RD, ST_DBL_WR, ST_SPL_SETUP,
    ST_SPL_DIR, ST_SPL_CP_RD, ST_SPL_CP_WR, ST_RED_RD, ST_RED_DIR,
    ST_RED_BKT, ST_RED_WR, ST_SPL_DONE, ST_OUT
  } state_t;
endpackage

### rtl/extendible_hash_set.sv
// top level of the extendible hash set: sequencer, directory, bucket and key memories
// a lookup scans its bucket slot by slot; a remove shifts the later slots down; an insert
//   that finds its bucket full may double the directory and split the bucket, then repeats
//   the lookup
// one transaction at a time: the sequencer takes a new request only in its idle state
// reset: a clearing pass over all 1024 directory entries rebuilds the directory and bucket tables, no items taken
`timescale 1ns / 1ps
module extendible_hash_set (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_code,
  output logic [13:0] key_count,
  output logic [9:0]  split_count,
  output logic [10:0] bucket_count,
  output logic [3:0]  global_depth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import ehs_pkg::*;

  logic [DirW-1:0]       dir_mem [DirSize];
  logic [GdW-1:0]        ld_mem  [DirSize];
  logic [FillW-1:0]      fc_mem  [DirSize];
  logic [31:0]           key_mem [DirSize*BucketSlots];

  state_t state, state_next;
  logic [3:0]  cap_reg;
  logic [1:0]  op;
  logic [31:0] k;
  logic [GdW-1:0] gd;
  logic [13:0] nkeys;
  logic [9:0]  nsplit;
  logic [1:0]  code;
  logic [DirW:0]   cnt;
  logic [DirW-1:0] idx, bkt, nb, step_i;
  logic [GdW-1:0]  ld;
  logic [FillW-1:0] fill, n;
  logic [SlotW:0]  s, found_s;
  logic            found;
  logic [31:0]     saved [BucketSlots];
  logic [31:0]     rk;
  logic [DirW-1:0] rd_dir;
  logic [GdW-1:0]  rd_ld;
  logic [FillW-1:0] rd_fc;
  logic [31:0]     rd_key;
  logic [DirW-1:0] rbkt;

  // memory port signals
  logic dir_we, ld_we, fc_we, key_we;
  logic [DirW-1:0] dir_ra, dir_wa, ld_ra, ld_wa, fc_ra, fc_wa;
  logic [DirW-1:0] dir_wd;
  logic [GdW-1:0]  ld_wd;
  logic [FillW-1:0] fc_wd;
  logic [KeyAddrW-1:0] key_ra, key_wa;
  logic [31:0] key_wd;

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    rd_dir <= dir_mem[dir_ra];
    if (ld_we) ld_mem[ld_wa] <= ld_wd;
    rd_ld <= ld_mem[ld_ra];
    if (fc_we) fc_mem[fc_wa] <= fc_wd;
    rd_fc <= fc_mem[fc_ra];
    if (key_we) key_mem[key_wa] <= key_wd;
    rd_key <= key_mem[key_ra];
  end

  logic [3:0] cap;
  always_comb begin
    cap = cap_reg;
    if (cap_reg == 4'd0) cap = 4'd1;
    if (cap_reg > 4'(BucketSlots)) cap = 4'(BucketSlots);
  end

  function automatic logic [DirW-1:0] lowbits(input logic [31:0] v, input logic [GdW-1:0] d);
    logic [DirW-1:0] m;
    m = DirW'((32'd1 << d) - 32'd1);
    return v[DirW-1:0] & m;
  endfunction

  logic [DirW-1:0] bitv;
  assign bitv = DirW'(32'd1 << ld);

  assign in_ready     = (state == ST_IDLE);
  assign cfg_ready    = (state == ST_IDLE) && !in_valid;
  assign out_valid    = (state == ST_OUT);
  assign result_code  = code;
  assign key_count    = nkeys;
  assign split_count  = nsplit;
  assign bucket_count = 11'(nsplit) + 11'd2;
  assign global_depth = gd;

  logic [DirW-1:0] size_m1;
  assign size_m1 = DirW'((32'd1 << gd) - 32'd1);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    dir_we = 1'b0; ld_we = 1'b0; fc_we = 1'b0; key_we = 1'b0;
    dir_ra = idx; dir_wa = cnt[DirW-1:0]; dir_wd = '0;
    ld_ra = bkt; ld_wa = bkt; ld_wd = '0;
    fc_ra = bkt; fc_wa = bkt; fc_wd = '0;
    key_ra = {bkt, s[SlotW-1:0]}; key_wa = {bkt, s[SlotW-1:0]}; key_wd = k;
    unique case (state)
      ST_INIT: begin
        dir_we = 1'b1; dir_wd = DirW'(cnt[0]);
        ld_we = 1'b1; ld_wa = cnt[DirW-1:0]; ld_wd = (cnt[DirW-1:1] == '0) ? GdW'(1) : '0;
        fc_we = 1'b1; fc_wa = cnt[DirW-1:0];
        if (cnt == (DirW+1)'(DirSize-1)) state_next = ST_IDLE;
      end
      ST_IDLE: if (in_valid) state_next = ST_DIR_RD;
      ST_DIR_RD: state_next = ST_BKT_RD;
      ST_BKT_RD: begin fc_ra = rd_dir; ld_ra = rd_dir; state_next = ST_SCAN_RD; end
      ST_SCAN_RD: begin
        if (found || s >= (SlotW+1)'(rd_fc)) state_next = ST_DECIDE;
        else state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: state_next = ST_SCAN_RD;
      ST_DECIDE: begin
        if (op == FuncContains) state_next = ST_OUT;
        else if (op == FuncInsert) state_next = found ? ST_OUT : ST_INS;
        else if (op == FuncRemove) state_next = found ? ST_RM_RD : ST_OUT;
        else state_next = ST_OUT;
      end
      ST_RM_RD: begin
        key_ra = {bkt, SlotW'(s + 1'b1)};
        if (s + 1'b1 >= (SlotW+1)'(fill)) begin
          fc_we = 1'b1; fc_wd = fill - 1'b1; state_next = ST_OUT;
        end else state_next = ST_RM_WR;
      end
      ST_RM_WR: begin key_we = 1'b1; key_wd = rd_key; state_next = ST_RM_RD; end
      ST_INS: begin
        // bkt, fill, ld hold current bucket
        if (4'(fill) < cap) begin
          key_we = 1'b1; key_wa = {bkt, SlotW'(fill)};
          fc_we = 1'b1; fc_wd = fill + 1'b1;
          state_next = ST_OUT;
        end else if (ld >= gd) begin
          if (gd >= GdW'(MaxGlobalDepth)) state_next = ST_OUT;
          else state_next = ST_DBL_RD;
        end else state_next = ST_SPL_SETUP;
      end
      ST_DBL_RD: begin dir_ra = cnt[DirW-1:0]; state_next = ST_DBL_WR; end
      ST_DBL_WR: begin
        dir_we = 1'b1; dir_wa = cnt[DirW-1:0] + size_m1 + 1'b1; dir_wd = rd_dir;
        state_next = (cnt[DirW-1:0] == size_m1) ? ST_SPL_SETUP : ST_DBL_RD;
      end
      ST_SPL_SETUP: begin
        ld_we = 1'b1; ld_wa = bkt; ld_wd = ld + 1'b1;
        state_next = ST_SPL_DIR;
      end
      ST_SPL_DIR: begin
        if (cnt == '0) begin
          ld_we = 1'b1; ld_wa = nb; ld_wd = ld + 1'b1;
          fc_we = 1'b1; fc_wa = nb;
        end
        dir_we = 1'b1; dir_wa = step_i; dir_wd = nb;
        if ((DirW+1)'(step_i) + (DirW+1)'({bitv, 1'b0}) > (DirW+1)'(size_m1))
          state_next = ST_SPL_CP_RD;
      end
      ST_SPL_CP_RD: begin
        key_ra = {bkt, s[SlotW-1:0]};
        if (s >= (SlotW+1)'(n)) begin
          fc_we = 1'b1; fc_wa = bkt; state_next = ST_RED_RD;
        end else state_next = ST_SPL_CP_WR;
      end
      ST_SPL_CP_WR: state_next = ST_SPL_CP_RD;
      ST_RED_RD: begin
        dir_ra = lowbits(saved[s[SlotW-1:0]], gd);
        state_next = (s >= (SlotW+1)'(n)) ? ST_SPL_DONE : ST_RED_DIR;
      end
      ST_RED_DIR: begin fc_ra = rd_dir; state_next = ST_RED_BKT; end
      ST_RED_BKT: begin fc_ra = rbkt; state_next = ST_RED_WR; end
      ST_RED_WR: begin
        if (rd_fc < FillW'(BucketSlots)) begin
          key_we = 1'b1; key_wa = {rbkt, SlotW'(rd_fc)}; key_wd = rk;
          fc_we = 1'b1; fc_wa = rbkt; fc_wd = rd_fc + 1'b1;
        end
        state_next = ST_RED_RD;
      end
      ST_SPL_DONE: state_next = ST_DIR_RD;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_SPL_DONE) dir_ra = lowbits(k, gd);
    if (state == ST_DIR_RD) begin fc_ra = rd_dir; ld_ra = rd_dir; end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= 4'd4; gd <= GdW'(1); nkeys <= '0; nsplit <= '0; cnt <= '0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
      unique case (state)
        ST_INIT: cnt <= cnt + 1'b1;
        ST_IDLE: if (in_valid) begin
          op <= func; k <= key; idx <= lowbits(key, gd); code <= ResMiss;
        end
        ST_DIR_RD: ;
        ST_BKT_RD: begin bkt <= rd_dir; s <= '0; found <= 1'b0; end
        ST_SCAN_RD: ;
        ST_SCAN_CHK: if (rd_key == k) begin found <= 1'b1; found_s <= s; end
                     else s <= s + 1'b1;
        ST_DECIDE: begin
          if (op == FuncContains) code <= found ? ResOk : ResMiss;
          if (op == FuncRemove && found) begin
            code <= ResOk; nkeys <= nkeys - 1'b1; s <= found_s;
          end
        end
        ST_RM_RD: ;
        ST_RM_WR: s <= s + 1'b1;
        ST_INS: begin
          cnt <= '0;
          if (4'(fill) < cap) begin code <= ResOk; nkeys <= nkeys + 1'b1; end
          else if (ld >= gd && gd >= GdW'(MaxGlobalDepth)) code <= ResFull;
        end
        ST_DBL_RD: ;
        ST_DBL_WR: begin
          if (cnt[DirW-1:0] == size_m1) begin gd <= gd + 1'b1; cnt <= '0; end
          else cnt <= cnt + 1'b1;
        end
        ST_SPL_SETUP: begin
          nb <= DirW'(nsplit) + DirW'(2);
          step_i <= (idx & (bitv - 1'b1)) | bitv;
          cnt <= '0;
        end
        ST_SPL_DIR: begin
          cnt <= cnt + 1'b1;
          step_i <= step_i + {bitv[DirW-2:0], 1'b0};
          n <= (fill > FillW'(BucketSlots)) ? FillW'(BucketSlots) : fill;
          s <= '0;
        end
        ST_SPL_CP_RD: if (s >= (SlotW+1)'(n)) s <= '0;
        ST_SPL_CP_WR: begin saved[s[SlotW-1:0]] <= rd_key; s <= s + 1'b1; end
        ST_RED_RD: rk <= saved[s[SlotW-1:0]];
        ST_RED_DIR: rbkt <= rd_dir;
        ST_RED_BKT: ;
        ST_RED_WR: s <= s + 1'b1;
        // the retry look-up after each split reuses the read path
        ST_SPL_DONE: begin nsplit <= nsplit + 1'b1; idx <= lowbits(k, gd); end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // bucket header capture after a directory lookup
  always_ff @(posedge clk) begin
    if (state == ST_SCAN_RD && s == '0 && !found) begin
      fill <= rd_fc; ld <= rd_ld;
    end
  end
endmodule

### tb/tb.sv
// testbench for the extendible hash set: scoreboard predictor, random traffic, back-pressure and an idle watchdog
`timescale 1ns / 1ps
module tb;
  import ehs_pkg::*;

  class hash_scoreboard;
    bit [9:0]  dir[DirSize];
    bit [3:0]  ldep[DirSize];
    bit [3:0]  fill[DirSize];
    bit [31:0] keys[DirSize][BucketSlots];
    int unsigned gdep, nkeys, nsplit;
    bit [3:0]  cap_reg;
    bit [1:0]  exp_code[$];
    int unsigned exp_keys[$], exp_split[$], exp_gd[$];
    int errors;

    function void clear();
      for (int i = 0; i < DirSize; i++) begin
        dir[i] = 10'(i & 1);
        ldep[i] = (i < 2) ? 4'd1 : 4'd0;
        fill[i] = '0;
      end
      gdep = 1;
      nkeys = 0;
      nsplit = 0;
      cap_reg = 4'd4;
      errors = 0;
    endfunction

    function int unsigned slot_of(int unsigned k);
      return k & ((1 << gdep) - 1);
    endfunction

    function int find(int unsigned b, bit [31:0] k);
      for (int s = 0; s < fill[b] && s < BucketSlots; s++)
        if (keys[b][s] == k) return s;
      return -1;
    endfunction

    function void push(int unsigned b, bit [31:0] k);
      if (fill[b] < BucketSlots) begin
        keys[b][fill[b]] = k;
        fill[b]++;
      end
    endfunction

    function void split(int unsigned idx);
      bit [31:0] saved[BucketSlots];
      int unsigned old, nb, d, size, bitv, n;
      old = dir[idx];
      nb = (2 + nsplit) & (DirSize - 1);
      d = ldep[old];
      size = 1 << gdep;
      bitv = 1 << d;
      ldep[old] = 4'(d + 1);
      ldep[nb] = 4'(d + 1);
      fill[nb] = '0;
      for (int unsigned i = (idx & (bitv - 1)) | bitv; i < size; i += bitv << 1)
        dir[i] = 10'(nb);
      n = (fill[old] > BucketSlots) ? BucketSlots : fill[old];
      for (int i = 0; i < n; i++) saved[i] = keys[old][i];
      fill[old] = '0;
      for (int i = 0; i < n; i++) push(dir[slot_of(saved[i])], saved[i]);
      nsplit++;
    endfunction

    function bit [1:0] insert(bit [31:0] k, int unsigned cap);
      int unsigned idx, b, size;
      forever begin
        idx = slot_of(k);
        b = dir[idx];
        if (fill[b] < cap) begin
          push(b, k);
          nkeys++;
          return ResOk;
        end
        if (ldep[b] >= gdep) begin
          if (gdep >= MaxGlobalDepth) return ResFull;
          size = 1 << gdep;
          for (int unsigned i = 0; i < size; i++) dir[i + size] = dir[i];
          gdep++;
        end
        split(idx);
      end
    endfunction

    function void note_op(bit [1:0] f, bit [31:0] k);
      int unsigned cap, b;
      int s;
      bit [1:0] code;
      cap = (cap_reg < 1) ? 1 : (cap_reg > BucketSlots) ? BucketSlots : cap_reg;
      b = dir[slot_of(k)];
      s = find(b, k);
      code = ResMiss;
      if (f == FuncContains) code = (s >= 0) ? ResOk : ResMiss;
      else if (f == FuncInsert) code = (s >= 0) ? ResMiss : insert(k, cap);
      else if (f == FuncRemove && s >= 0) begin
        for (int i = s; i < fill[b] - 1; i++) keys[b][i] = keys[b][i + 1];
        fill[b]--;
        nkeys--;
        code = ResOk;
      end
      exp_code = {exp_code, code};
      exp_keys = {exp_keys, nkeys};
      exp_split = {exp_split, nsplit};
      exp_gd = {exp_gd, gdep};
    endfunction

    function void check_result(bit [1:0] rc, bit [13:0] kc, bit [9:0] sc, bit [10:0] bc,
                               bit [3:0] gd);
      bit [1:0] ec;
      int unsigned ek, es, eg;
      if (exp_code.size() == 0) begin
        $display("%0t unexpected result code %0d", $time, rc);
        errors++;
        return;
      end
      ec = exp_code.pop_front();
      ek = exp_keys.pop_front();
      es = exp_split.pop_front();
      eg = exp_gd.pop_front();
      if (rc != ec) begin
        $display("%0t result_code expected %0d actual %0d", $time, ec, rc); errors++;
      end
      if (kc != ek[13:0]) begin
        $display("%0t key_count expected %0d actual %0d", $time, ek, kc); errors++;
      end
      if (sc != es[9:0]) begin
        $display("%0t split_count expected %0d actual %0d", $time, es, sc); errors++;
      end
      if (bc != 11'(es + 2)) begin
        $display("%0t bucket_count expected %0d actual %0d", $time, es + 2, bc); errors++;
      end
      if (gd != eg[3:0]) begin
        $display("%0t global_depth expected %0d actual %0d", $time, eg, gd); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [1:0] func, result_code;
  logic [31:0] key;
  logic [13:0] key_count;
  logic [9:0] split_count;
  logic [10:0] bucket_count;
  logic [3:0] global_depth, cfg_data;

  hash_scoreboard sb;
  int stall_mode;   // 0 random, 1 none, 2 long hold-off
  bit gaps_on;
  int idle_cycles;
  bit [31:0] recent[$];

  extendible_hash_set dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .func(func), .key(key),
    .out_valid(out_valid), .out_ready(out_ready), .result_code(result_code),
    .key_count(key_count), .split_count(split_count), .bucket_count(bucket_count),
    .global_depth(global_depth), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_op(func, key);
      if (out_valid && out_ready)
        sb.check_result(result_code, key_count, split_count, bucket_count, global_depth);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 200000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (stall_mode == 2) begin
        out_ready = 0;
        repeat (300) @(negedge clk);
        stall_mode = 0;
      end else if (stall_mode == 0 && $urandom_range(0, 4) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready = 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_op(bit [1:0] f, bit [31:0] k);
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
    in_valid = 1;
    func = f;
    key = k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (sb.exp_code.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cap(bit [3:0] v);
    drain();
    cfg_valid = 1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.cap_reg = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic bit [31:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
    if (r < 7) return $urandom_range(0, 63);
    if (r < 8) return ($urandom() & 32'hfff) << 10;
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    bit [31:0] k;
    int r;
    bit [1:0] f;
    for (int i = 0; i < n; i++) begin
      k = pick_key();
      r = $urandom_range(0, 19);
      f = (r < 9) ? FuncInsert : (r < 14) ? FuncContains : (r < 19) ? FuncRemove : 2'd3;
      if (f == FuncInsert && recent.size() < 64) recent = {recent, k};
      send_op(f, k);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1; in_valid = 0; func = 0; key = 0; cfg_valid = 0; cfg_data = 0;
    stall_mode = 1; gaps_on = 1; idle_cycles = 0;
    repeat (8) @(negedge clk);
    rst = 0;
    stall_mode = 0;

    send_op(FuncContains, 32'h0);
    send_op(FuncInsert, 32'h0);
    send_op(FuncInsert, 32'h0);
    send_op(FuncInsert, 32'hffffffff);
    send_op(FuncContains, 32'hffffffff);
    send_op(FuncRemove, 32'hffffffff);
    send_op(FuncRemove, 32'hffffffff);
    send_op(2'd3, 32'h0);
    send_op(FuncInsert, 32'haaaaaaaa);
    send_op(FuncInsert, 32'h55555555);
    write_cap(4'd1);
    // same low bits force the directory to its limit
    for (int i = 1; i <= 12; i++) send_op(FuncInsert, i << 10);
    send_op(FuncContains, 32'h00000400);
    write_cap(4'd0);
    random_phase(100);
    write_cap(4'd15);
    stall_mode = 2;
    random_phase(100);
    drain();
    write_cap(4'd8);
    random_phase(150);
    write_cap(4'd3);
    random_phase(150);
    write_cap(4'd4);
    stall_mode = 1;
    gaps_on = 0;
    random_phase(130);
    drain();

    if (sb.errors == 0 && sb.exp_code.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/ehs_pkg.sv
rtl/extendible_hash_set.sv
tb/tb.sv
